>>> src/trimmed_mean_level_classifier_macros.svh
// Assertion macros used by the trimmed-mean level classifier checker.
`ifndef TRIMMED_MEAN_LEVEL_CLASSIFIER_MACROS_SVH
`define TRIMMED_MEAN_LEVEL_CLASSIFIER_MACROS_SVH

// Checks a property on every rising clock edge while reset is released.
`define TMLC_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Checks that a condition in one cycle implies another condition in the next cycle.
`define TMLC_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

>>> src/tmlc_pkg.sv
// Shared constants, types and the level classification function of the classifier.
package tmlc_pkg;

  localparam int unsigned SampleCount = 10;
  localparam int unsigned IdxW        = $clog2(SampleCount);
  localparam int unsigned SampleW     = 16;
  localparam int unsigned TrimLo      = 2;
  localparam int unsigned TrimHi      = 7;
  localparam int unsigned TrimN       = TrimHi - TrimLo + 1;
  localparam int unsigned RaW         = $clog2(TrimHi + 2);
  localparam int unsigned SumW        = $clog2(TrimN * ((1 << SampleW) - 1) + 1);

  // Division by six as a multiplication by ceil(2^20 / 6); exact for sums below 2^19.
  localparam int unsigned RecipShift  = 20;
  localparam int unsigned RecipW      = 18;
  localparam logic [RecipW-1:0] Recip = RecipW'(((1 << RecipShift) + TrimN - 1) / TrimN);
  localparam int unsigned ProdW       = SumW + RecipW;

  localparam int unsigned CodeW       = 5;
  localparam int unsigned AddrW       = 5;
  localparam int unsigned DataW       = 32;

  localparam logic [CodeW-1:0] LevelFull = 5'd16;
  localparam logic [CodeW-1:0] Level5    = 5'd5;
  localparam logic [CodeW-1:0] Level4    = 5'd4;
  localparam logic [CodeW-1:0] Level3    = 5'd3;
  localparam logic [CodeW-1:0] Level2    = 5'd2;
  localparam logic [CodeW-1:0] Level1    = 5'd1;

  typedef enum logic [2:0] {
    RegFull   = 3'd0,
    RegLevel5 = 3'd1,
    RegLevel4 = 3'd2,
    RegLevel3 = 3'd3,
    RegLevel2 = 3'd4
  } reg_idx_e;

  typedef struct packed {
    logic [SampleW-1:0] full;
    logic [SampleW-1:0] lvl5;
    logic [SampleW-1:0] lvl4;
    logic [SampleW-1:0] lvl3;
    logic [SampleW-1:0] lvl2;
  } thr_t;

  // The first threshold that the mean exceeds, tested from full down to level 2, decides the code.
  function automatic logic [CodeW-1:0] classify(logic [SampleW-1:0] mean, thr_t thr);
    logic [CodeW-1:0] code;
    priority if (mean > thr.full) begin
      code = LevelFull;
    end else if (mean > thr.lvl5) begin
      code = Level5;
    end else if (mean > thr.lvl4) begin
      code = Level4;
    end else if (mean > thr.lvl3) begin
      code = Level3;
    end else if (mean > thr.lvl2) begin
      code = Level2;
    end else begin
      code = Level1;
    end
    return code;
  endfunction

endpackage

>>> src/tmlc_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
module tmlc_ram #(
  parameter int unsigned Depth = 10,
  parameter int unsigned Width = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> src/tmlc_regs.sv
// APB register bank holding the five level thresholds.
module tmlc_regs (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [tmlc_pkg::AddrW-1:0]  paddr,
  input  logic [tmlc_pkg::DataW-1:0]  pwdata,
  output logic [tmlc_pkg::DataW-1:0]  prdata,
  output logic                        pready,
  output tmlc_pkg::thr_t              thr_o
);
  import tmlc_pkg::*;

  thr_t     thr_q;
  reg_idx_e idx;
  logic     wr_en;

  assign pready = 1'b1;
  assign idx    = reg_idx_e'(paddr[AddrW-1:2]);
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q.full <= 16'd31851;
      thr_q.lvl5 <= 16'd31434;
      thr_q.lvl4 <= 16'd30879;
      thr_q.lvl3 <= 16'd30212;
      thr_q.lvl2 <= 16'd28879;
    end else if (wr_en) begin
      unique case (idx)
        RegFull:   thr_q.full <= pwdata[SampleW-1:0];
        RegLevel5: thr_q.lvl5 <= pwdata[SampleW-1:0];
        RegLevel4: thr_q.lvl4 <= pwdata[SampleW-1:0];
        RegLevel3: thr_q.lvl3 <= pwdata[SampleW-1:0];
        RegLevel2: thr_q.lvl2 <= pwdata[SampleW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      RegFull:   prdata = DataW'(thr_q.full);
      RegLevel5: prdata = DataW'(thr_q.lvl5);
      RegLevel4: prdata = DataW'(thr_q.lvl4);
      RegLevel3: prdata = DataW'(thr_q.lvl3);
      RegLevel2: prdata = DataW'(thr_q.lvl2);
      default:   prdata = '0;
    endcase
  end

  assign thr_o = thr_q;

endmodule

>>> src/trimmed_mean_level_classifier.sv
// Top level of the trimmed-mean battery level classifier.
//
// Raw 16-bit converter readings arrive as requests on the slave stream. The
// block collects them in batches of ten and keeps the batch in a small RAM in
// ascending order, inserting each new reading by shifting larger entries up
// one place per cycle. A reading is accepted, then walks down past each larger
// entry over the RAM's single read port and is written where it lands; no new
// reading is accepted until that write. The tenth reading of a batch is
// followed by a pass that reads sorted positions two through seven and sums
// them, a reciprocal multiply for the division by six and the load of the
// output register. One result request per batch leaves on the master stream:
// level code in the low bits, the mean above it. The output register separates
// the two sides: new readings are accepted while a result waits. Only when a
// batch completes while the previous result is still unclaimed does the block
// hold in its final step until the receiver takes it. Reset empties the batch,
// drops any pending result and restores the default thresholds; the RAM
// contents are not cleared. The user must write thresholds over the APB port
// only while the block is idle; the block itself does not enforce this.
module trimmed_mean_level_classifier (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // Slave stream. tdata: [15:0] raw_sample.
  input  logic                        s_axis_tvalid_i,
  output logic                        s_axis_tready_o,
  input  logic [15:0]                 s_axis_tdata_i,
  // Master stream. tdata: [4:0] level_code, [20:5] trimmed_mean, [23:21] zero.
  output logic                        m_axis_tvalid_o,
  input  logic                        m_axis_tready_i,
  output logic [23:0]                 m_axis_tdata_o,
  // Configuration port.
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [tmlc_pkg::AddrW-1:0]  paddr,
  input  logic [tmlc_pkg::DataW-1:0]  pwdata,
  output logic [tmlc_pkg::DataW-1:0]  prdata,
  output logic                        pready
);
  import tmlc_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INSERT,
    ST_SUM,
    ST_SCALE,
    ST_EMIT
  } state_e;

  state_e              state_q;
  logic [IdxW-1:0]     held_q;
  logic [IdxW-1:0]     pos_q;
  logic [RaW-1:0]      ra_q;
  logic                rvld_q;
  logic                out_vld_q;
  logic [SampleW-1:0]  smp_q;
  logic [SumW-1:0]     acc_q;
  logic [ProdW-1:0]    prod_q;
  logic [CodeW-1:0]    out_code_q;
  logic [SampleW-1:0]  out_mean_q;

  thr_t                thr;
  logic                in_acc;
  logic                shift;
  logic                last_smp;
  logic                emit_ok;
  logic                ram_we;
  logic [IdxW-1:0]     ram_raddr;
  logic [SampleW-1:0]  ram_wdata;
  logic [SampleW-1:0]  ram_rdata;
  logic [SampleW-1:0]  mean;

  tmlc_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .thr_o   (thr)
  );

  tmlc_ram #(
    .Depth (SampleCount),
    .Width (SampleW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (pos_q),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign in_acc          = s_axis_tvalid_i && s_axis_tready_o;

  // While inserting, the read data is always the entry just below pos_q.
  // A larger entry moves up one place; otherwise the new reading lands here,
  // which also keeps equal readings in arrival order.
  assign shift     = (pos_q != '0) && (ram_rdata > smp_q);
  assign last_smp  = (held_q == IdxW'(SampleCount - 1));
  assign ram_we    = (state_q == ST_INSERT);
  assign ram_wdata = shift ? ram_rdata : smp_q;
  assign emit_ok   = !out_vld_q || m_axis_tready_i;
  assign mean      = prod_q[RecipShift +: SampleW];

  // The read address runs two entries below the write address during the
  // walk, so a read never meets a write to the same entry.
  always_comb begin
    unique case (state_q)
      ST_IDLE:   ram_raddr = held_q - IdxW'(1);
      ST_INSERT: ram_raddr = pos_q - IdxW'(2);
      ST_SUM:    ram_raddr = ra_q[IdxW-1:0];
      default:   ram_raddr = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      held_q    <= '0;
      pos_q     <= '0;
      ra_q      <= '0;
      rvld_q    <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      rvld_q <= (state_q == ST_SUM) && (ra_q <= RaW'(TrimHi));
      // A new result takes the output register as the old one leaves it.
      if ((state_q == ST_EMIT) && emit_ok) begin
        out_vld_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_vld_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            pos_q   <= held_q;
            state_q <= ST_INSERT;
          end
        end
        ST_INSERT: begin
          if (shift) begin
            pos_q <= pos_q - IdxW'(1);
          end else if (last_smp) begin
            held_q  <= '0;
            ra_q    <= RaW'(TrimLo);
            state_q <= ST_SUM;
          end else begin
            held_q  <= held_q + IdxW'(1);
            state_q <= ST_IDLE;
          end
        end
        ST_SUM: begin
          if (ra_q <= RaW'(TrimHi)) begin
            ra_q <= ra_q + RaW'(1);
          end else if (!rvld_q) begin
            state_q <= ST_SCALE;
          end
        end
        ST_SCALE: begin
          state_q <= ST_EMIT;
        end
        ST_EMIT: begin
          if (emit_ok) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      smp_q <= s_axis_tdata_i;
    end
    if ((state_q == ST_INSERT) && !shift && last_smp) begin
      acc_q <= '0;
    end else if (rvld_q) begin
      acc_q <= acc_q + SumW'(ram_rdata);
    end
    if (state_q == ST_SCALE) begin
      prod_q <= ProdW'(acc_q) * ProdW'(Recip);
    end
    if ((state_q == ST_EMIT) && emit_ok) begin
      out_mean_q <= mean;
      out_code_q <= classify(mean, thr);
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = {3'b000, out_mean_q, out_code_q};

endmodule

>>> src/tmlc_checker.sv
// Port-level checker for the classifier and the bind that attaches it.
`include "trimmed_mean_level_classifier_macros.svh"

module tmlc_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid_i,
  input logic        s_axis_tready_o,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [23:0] m_axis_tdata_o
);

  // The input is closed in the cycle after each accepted reading.
  `TMLC_ASSERT_NEXT(a_busy_after_accept, clk_i, rst_ni, s_axis_tvalid_i && s_axis_tready_o, !s_axis_tready_o, "input ready right after an accepted request")

  // A result is never issued in the cycle right after a reading is accepted.
  `TMLC_ASSERT_NEXT(a_no_instant_result, clk_i, rst_ni, s_axis_tvalid_i && s_axis_tready_o, !$rose(m_axis_tvalid_o), "result appeared immediately after a request")

  // Only the six defined level codes may leave the block.
  `TMLC_ASSERT(a_code_legal, clk_i, rst_ni, m_axis_tvalid_o |-> (m_axis_tdata_o[4:0] == 5'd1 || m_axis_tdata_o[4:0] == 5'd2 || m_axis_tdata_o[4:0] == 5'd3 || m_axis_tdata_o[4:0] == 5'd4 || m_axis_tdata_o[4:0] == 5'd5 || m_axis_tdata_o[4:0] == 5'd16), "illegal level code")

  // A stalled result stays valid and unchanged.
  `TMLC_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, m_axis_tvalid_o && !m_axis_tready_i, m_axis_tvalid_o && $stable(m_axis_tdata_o), "stalled result changed")

endmodule

bind trimmed_mean_level_classifier tmlc_checker u_tmlc_checker (.*);

>>> tb/trimmed_mean_level_classifier_test.sv
// Self-checking testbench for the trimmed-mean battery level classifier.
`timescale 1ns / 100ps

// Raw samples go in on the slave stream as requests. Every tenth one closes a batch, and
// the block answers with one request on the master stream that carries the trimmed mean and a
// level code. The bench keeps its own sorted copy of each batch, works out the mean and the
// level from its copy of the thresholds, and checks every report field by field in order.
//
// The run opens with a short table of directed samples: a batch of all zeros, a batch of all
// full-scale readings and the start of a mixed batch. After that come phases of random
// batches. Each phase first programs a new threshold set over APB, with the block idle, and
// reads the set back. The sets include all zeros, all ones, the reset values, an ascending
// (inverted) order and random sets, and one phase also writes an unmapped address.
module trimmed_mean_level_classifier_test;
  import tmlc_pkg::*;

  localparam int unsigned NumRegs        = 5;
  localparam int unsigned RegStride      = 4;
  localparam int          MaxSample      = (1 << SampleW) - 1;
  localparam int unsigned ResetCycles    = 11;
  localparam int unsigned MaxGap         = 17;
  // Wait after the last owed report, so the block can finish inserting a sample that closes no batch.
  localparam int unsigned SettleCycles   = 40;
  localparam int unsigned HoldCycles     = 700;
  localparam int unsigned NumPhases      = 14;
  localparam int unsigned SamplesPerPhase = 125;
  localparam int unsigned NumDirected    = 25;

  // Threshold sets that the first phases use. The later phases draw theirs at random.
  localparam int unsigned PhaseAllZero   = 0;
  localparam int unsigned PhaseAllOnes   = 1;
  localparam int unsigned PhaseDefaults  = 2;
  localparam int unsigned PhaseAscending = 3;
  // In this phase the receiver stops for a long time while the sender keeps going.
  localparam int unsigned PhaseHold      = 4;

  localparam logic [AddrW-1:0] UnmappedAddr = 5'd20;

  localparam logic [SampleW-1:0] ResetThr [NumRegs] = '{
    16'd31851, 16'd31434, 16'd30879, 16'd30212, 16'd28879
  };
  localparam logic [CodeW-1:0] LevelByReg [NumRegs] = '{
    LevelFull, Level5, Level4, Level3, Level2
  };

  typedef struct packed {
    logic [CodeW-1:0]   code;
    logic [SampleW-1:0] mean;
  } level_report_t;

  typedef struct packed {
    logic [SampleW-1:0] sample;
    bit                 typed;
    logic [CodeW-1:0]   code;
    logic [SampleW-1:0] mean;
  } directed_row_t;

  typedef enum logic [1:0] {
    SpreadWide,
    SpreadNear,
    SpreadFlat,
    SpreadOutliers
  } batch_shape_e;

  // Only the last row of each of the first two batches has an expected report typed in. The
  // zeros give a mean of 0, which is below every default threshold. The full-scale readings
  // give 65535, which is above them all. The other rows go through the predictor.
  localparam directed_row_t DirectedRows [NumDirected] = '{
    '{16'h0000, 1'b0, '0, '0}, '{16'h0000, 1'b0, '0, '0}, '{16'h0000, 1'b0, '0, '0},
    '{16'h0000, 1'b0, '0, '0}, '{16'h0000, 1'b0, '0, '0}, '{16'h0000, 1'b0, '0, '0},
    '{16'h0000, 1'b0, '0, '0}, '{16'h0000, 1'b0, '0, '0}, '{16'h0000, 1'b0, '0, '0},
    '{16'h0000, 1'b1, Level1, 16'h0000},
    '{16'hFFFF, 1'b0, '0, '0}, '{16'hFFFF, 1'b0, '0, '0}, '{16'hFFFF, 1'b0, '0, '0},
    '{16'hFFFF, 1'b0, '0, '0}, '{16'hFFFF, 1'b0, '0, '0}, '{16'hFFFF, 1'b0, '0, '0},
    '{16'hFFFF, 1'b0, '0, '0}, '{16'hFFFF, 1'b0, '0, '0}, '{16'hFFFF, 1'b0, '0, '0},
    '{16'hFFFF, 1'b1, LevelFull, 16'hFFFF},
    '{16'h8000, 1'b0, '0, '0}, '{16'h7FFF, 1'b0, '0, '0}, '{16'h0001, 1'b0, '0, '0},
    '{16'hFFFE, 1'b0, '0, '0}, '{16'h5555, 1'b0, '0, '0}
  };

  logic                 clk_i           = 1'b0;
  logic                 rst_ni          = 1'b0;
  logic                 s_axis_tvalid_i = 1'b0;
  logic                 s_axis_tready_o;
  logic [15:0]          s_axis_tdata_i  = '0;   // [15:0] raw_sample
  logic                 m_axis_tvalid_o;
  logic                 m_axis_tready_i = 1'b0;
  logic [23:0]          m_axis_tdata_o;         // [4:0] level_code, [20:5] trimmed_mean
  logic                 psel            = 1'b0;
  logic                 penable         = 1'b0;
  logic                 pwrite          = 1'b0;
  logic [AddrW-1:0]     paddr           = '0;
  logic [DataW-1:0]     pwdata          = '0;
  logic [DataW-1:0]     prdata;
  logic                 pready;

  // This is the bench's own picture of the block: the thresholds, the partly filled batch
  // held in ascending order, and the reports that are still owed.
  logic [SampleW-1:0]   level_thr [NumRegs] = ResetThr;
  logic [SampleW-1:0]   batch_sorted [SampleCount];
  int unsigned          batch_fill = 0;
  level_report_t        pending_reports [$];

  logic [SampleW-1:0]   next_thr [NumRegs];
  batch_shape_e         batch_shape = SpreadWide;
  int                   batch_center = 0;

  bit                   no_idle = 1'b0;
  bit                   hold_results = 1'b0;
  int unsigned          mismatch_count = 0;
  int unsigned          samples_sent = 0;
  int unsigned          reports_checked = 0;

  trimmed_mean_level_classifier i_dut (
    .clk_i,
    .rst_ni,
    .s_axis_tvalid_i,
    .s_axis_tready_o,
    .s_axis_tdata_i,
    .m_axis_tvalid_o,
    .m_axis_tready_i,
    .m_axis_tdata_o,
    .psel,
    .penable,
    .pwrite,
    .paddr,
    .pwdata,
    .prdata,
    .pready
  );

  initial begin : clock_gen
    forever #10 clk_i = ~clk_i;
  end

  initial begin : run_limit
    #10_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  // Puts one accepted sample into the batch. When the sample closes the batch, this returns
  // 1 and gives the report that the block owes.
  function automatic bit predict_report(input logic [SampleW-1:0] v,
                                        output level_report_t rep);
    int unsigned pos;
    int unsigned sum;
    bit          found;
    pos = batch_fill;
    // A new sample goes after any stored samples that are equal to it.
    while (pos > 0 && batch_sorted[pos-1] > v) begin
      batch_sorted[pos] = batch_sorted[pos-1];
      pos--;
    end
    batch_sorted[pos] = v;
    batch_fill++;
    rep = '0;
    if (batch_fill < SampleCount) begin
      return 1'b0;
    end
    sum = 0;
    for (int unsigned k = TrimLo; k <= TrimHi; k++) begin
      sum += batch_sorted[k];
    end
    rep.mean = SampleW'(sum / TrimN);
    batch_fill = 0;
    // The thresholds are tested from full down to level 2, whatever their order. The first
    // test that passes decides the code.
    rep.code = Level1;
    found = 1'b0;
    for (int k = 0; k < NumRegs; k++) begin
      if (!found && rep.mean > level_thr[k]) begin
        rep.code = LevelByReg[k];
        found = 1'b1;
      end
    end
    return 1'b1;
  endfunction

  // The receiver draws a stall before each report, except in phases with no gaps. Once the
  // stimulus asks for it, it also holds tready low for one long stretch, which it counts here.
  initial begin : report_sink
    int unsigned gap;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_results) begin
        m_axis_tready_i <= 1'b0;
        repeat (HoldCycles) @(negedge clk_i);
        hold_results = 1'b0;
      end
      gap = no_idle ? 0 : $urandom_range(0, MaxGap);
      if (gap != 0) begin
        m_axis_tready_i <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      m_axis_tready_i <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid_o);
    end
  end

  always @(posedge clk_i) begin : report_check
    level_report_t want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (pending_reports.size() == 0) begin
        mismatch_count++;
        $display("%0t: report with none expected, expected nothing, actual %h",
                 $time, m_axis_tdata_o);
      end else begin
        want = pending_reports.pop_front();
        reports_checked++;
        if (m_axis_tdata_o[CodeW-1:0] != want.code) begin
          mismatch_count++;
          $display("%0t: level code mismatch, expected %0d, actual %0d",
                   $time, want.code, m_axis_tdata_o[CodeW-1:0]);
        end
        if (m_axis_tdata_o[CodeW+SampleW-1:CodeW] != want.mean) begin
          mismatch_count++;
          $display("%0t: trimmed mean mismatch, expected %0d, actual %0d",
                   $time, want.mean, m_axis_tdata_o[CodeW+SampleW-1:CodeW]);
        end
        if (m_axis_tdata_o[23:CodeW+SampleW] != '0) begin
          mismatch_count++;
          $display("%0t: report padding mismatch, expected 0, actual %h",
                   $time, m_axis_tdata_o[23:CodeW+SampleW]);
        end
      end
    end
  end

  // Offers one sample after a random gap, or none when no_idle is set, and waits until the block
  // takes it. tvalid stays high afterward, so the next sample can follow with no gap.
  task automatic push_sample(input logic [SampleW-1:0] v, input bit use_typed,
                             input level_report_t typed_rep);
    int unsigned   gap;
    level_report_t rep;
    gap = no_idle ? 0 : $urandom_range(0, MaxGap);
    @(negedge clk_i);
    if (gap != 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= v;
    do @(posedge clk_i); while (!s_axis_tready_o);
    samples_sent++;
    if (predict_report(v, rep)) begin
      pending_reports.push_back(use_typed ? typed_rep : rep);
    end
  endtask

  // Stops sending and waits until every owed report has arrived. It then waits further, so
  // that the block can finish inserting a sample that closes no batch.
  task automatic wait_for_reports();
    @(negedge clk_i);
    s_axis_tvalid_i <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic apb_write(input logic [AddrW-1:0] addr, input logic [DataW-1:0] data);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    // The threshold registers keep only the low 16 bits. Addresses past the last register
    // are ignored.
    if (addr[1:0] == 2'b00 && addr[AddrW-1:2] <= RegLevel2) begin
      level_thr[addr[AddrW-1:2]] = data[SampleW-1:0];
    end
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Reads every threshold back and compares it with the expected value.
  task automatic check_thresholds();
    logic [DataW-1:0] got;
    for (int k = 0; k <= RegLevel2; k++) begin
      @(negedge clk_i);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      paddr   <= AddrW'(k * RegStride);
      @(negedge clk_i);
      penable <= 1'b1;
      do @(posedge clk_i); while (!pready);
      got = prdata;
      if (got[SampleW-1:0] != level_thr[k]) begin
        mismatch_count++;
        $display("%0t: threshold %0d readback mismatch, expected %0d, actual %0d",
                 $time, k, level_thr[k], got[SampleW-1:0]);
      end
      @(negedge clk_i);
      psel    <= 1'b0;
      penable <= 1'b0;
    end
  endtask

  // Picks the threshold set of a phase. Random sets are mostly in descending order, so that
  // every level can be reached, and sometimes left in any order.
  task automatic draw_thresholds(input int unsigned phase);
    logic [SampleW-1:0] swap;
    for (int k = 0; k < NumRegs; k++) begin
      case (phase)
        PhaseAllZero:   next_thr[k] = '0;
        PhaseAllOnes:   next_thr[k] = '1;
        PhaseDefaults:  next_thr[k] = ResetThr[k];
        PhaseAscending: next_thr[k] = SampleW'((k + 1) * 16'h2000);
        default:        next_thr[k] = SampleW'($urandom);
      endcase
    end
    if (phase > PhaseAscending && $urandom_range(0, 3) != 0) begin
      for (int i = 0; i < NumRegs - 1; i++) begin
        for (int j = 0; j < NumRegs - 1 - i; j++) begin
          if (next_thr[j] < next_thr[j+1]) begin
            swap          = next_thr[j];
            next_thr[j]   = next_thr[j+1];
            next_thr[j+1] = swap;
          end
        end
      end
    end
  endtask

  // Gives the next random sample. Each batch has a shape of its own. The samples may spread
  // over the whole range, sit close to one threshold, all be equal, or sit around a center
  // with extreme readings mixed in. The two lowest and two highest sorted positions are trimmed.
  function automatic logic [SampleW-1:0] next_sample();
    int v;
    if (batch_fill == 0) begin
      batch_shape  = batch_shape_e'($urandom_range(0, 3));
      batch_center = (batch_shape == SpreadNear)
                     ? int'(level_thr[$urandom_range(0, NumRegs - 1)])
                     : int'($urandom_range(0, MaxSample));
    end
    case (batch_shape)
      SpreadNear:  v = batch_center + int'($urandom_range(0, 96)) - 48;
      SpreadFlat:  v = batch_center;
      SpreadOutliers: begin
        if ($urandom_range(0, 3) == 0) begin
          v = $urandom_range(0, 1) ? MaxSample : 0;
        end else begin
          v = batch_center + int'($urandom_range(0, 512)) - 256;
        end
      end
      default:     v = int'($urandom_range(0, MaxSample));
    endcase
    if (v < 0) begin
      v = 0;
    end else if (v > MaxSample) begin
      v = MaxSample;
    end
    return SampleW'(v);
  endfunction

  initial begin : stimulus
    level_report_t typed_rep;
    repeat (ResetCycles) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // After reset the registers must hold their default thresholds.
    check_thresholds();

    foreach (DirectedRows[i]) begin
      typed_rep.code = DirectedRows[i].code;
      typed_rep.mean = DirectedRows[i].mean;
      push_sample(DirectedRows[i].sample, DirectedRows[i].typed, typed_rep);
    end
    wait_for_reports();

    for (int unsigned phase = 0; phase < NumPhases; phase++) begin
      // Thresholds change only here, while the sender is stopped and no report is owed.
      draw_thresholds(phase);
      for (int k = 0; k <= RegLevel2; k++) begin
        apb_write(AddrW'(k * RegStride), DataW'({$urandom, next_thr[k]}));
      end
      if (phase == PhaseAllZero) begin
        apb_write(UnmappedAddr, DataW'($urandom));
      end
      check_thresholds();

      // In some phases both sides run with no gaps. The hold phase also does, so the sender
      // keeps the input full while the receiver is stalled.
      no_idle = (phase == PhaseHold) || (phase % 5 == 3);
      if (phase == PhaseHold) begin
        hold_results = 1'b1;
      end
      repeat (SamplesPerPhase) begin
        push_sample(next_sample(), 1'b0, '0);
      end
      wait_for_reports();
      no_idle = 1'b0;
    end

    if (pending_reports.size() != 0) begin
      mismatch_count++;
      $display("%0t: reports never arrived, expected %0d more, actual 0",
               $time, pending_reports.size());
    end
    $display("Covered %0d samples and %0d level reports over %0d threshold sets,",
             samples_sent, reports_checked, NumPhases + 1);
    $display("including inverted thresholds, a long output stall and randomized gaps.");
    if (mismatch_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

>>> trimmed_mean_level_classifier.f
+incdir+src
src/tmlc_pkg.sv
src/tmlc_ram.sv
src/tmlc_regs.sv
src/trimmed_mean_level_classifier.sv
src/tmlc_checker.sv
tb/trimmed_mean_level_classifier_test.sv
